### design/rcg_pkg.sv
// Shared types and codes for the ring cadence generator.
// Has no dependencies; ring_cadence_generator, rcg_cfg_regs and rcg_cadence import it.

package rcg_pkg;

  // Action codes carried by an input item. Code 3 has no meaning.
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_t;

  // Register indexes on the configuration channel.
  localparam int unsigned CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ON_DURATION  = 2'd0,
    CFG_OFF_DURATION = 2'd1,
    CFG_RING_LIMIT   = 2'd2
  } cfg_index_t;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned DURATION_W  = 16;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned TIME_W      = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Current register settings, handed from the register file to the cadence core.
  typedef struct packed {
    logic [DURATION_W-1:0] on_duration;
    logic [DURATION_W-1:0] off_duration;
    logic [COUNT_W-1:0]    ring_limit;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic edge_seen;
    logic bell_level;
    logic ringing_active;
  } result_t;

endpackage

### design/rcg_item_if.sv
// Valid/ready channel that carries one input item (action and time stamp).
// Depends on nothing; widths match rcg_pkg.

interface rcg_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] time_now;

  modport source (output valid, output action, output time_now, input ready);
  modport sink (input valid, input action, input time_now, output ready);
endinterface

### design/rcg_result_if.sv
// Valid/ready channel that carries one result item.
// Depends on nothing.

interface rcg_result_if;
  logic valid;
  logic ready;
  logic edge_seen;
  logic bell_level;
  logic ringing_active;

  modport source (output valid, output edge_seen, output bell_level,
                  output ringing_active, input ready);
  modport sink (input valid, input edge_seen, input bell_level,
                input ringing_active, output ready);
endinterface

### design/rcg_cfg_if.sv
// Valid/ready write channel for the configuration registers.
// Depends on nothing; widths match rcg_pkg.

interface rcg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/ring_cadence_generator.sv
// Ring cadence generator, top level: input register, cadence core and
// result register. Depends on rcg_pkg, the three channel interfaces,
// rcg_cfg_regs and rcg_cadence.
//
// Usage: items arrive on the item channel (action and millisecond time);
// every item gives exactly one result on the result channel (edge_seen,
// bell_level, ringing_active). Registers are written through the cfg
// channel, which is always ready; write them only while no item is in flight.
// After the item transfer, an item is held in the input register and then its
// result in the result register, which drives the result channel. Throughput
// is one item per cycle while the receiver takes results, set by the
// combinational subtract and compare of the cadence core, which reads and
// updates its state as an item passes from the input register to the result
// register.
// Reset clears the registers, the cadence state and both pipeline stages.
// When the receiver stalls, the result register holds its item, the input
// register fills, and item.ready then drops until the result is taken.

module ring_cadence_generator (
  input  logic             clk,
  input  logic             rst,
  rcg_item_if.sink         item,
  rcg_result_if.source     result,
  rcg_cfg_if.sink          cfg
);
  import rcg_pkg::*;

  cfg_t    cfg_vals;
  result_t core_result;

  // Input register.
  logic              in_valid;
  logic [1:0]        in_action;
  logic [TIME_W-1:0] in_time;

  // Result register.
  logic    out_valid;
  result_t out_data;

  logic advance;

  // An item leaves the input register whenever the result register can take it.
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;
  assign cfg.ready  = 1'b1;

  rcg_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_vals)
  );

  rcg_cadence u_cadence (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_vals),
    .step     (advance),
    .action   (in_action),
    .time_now (in_time),
    .result   (core_result)
  );

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      in_action <= item.action;
      in_time   <= item.time_now;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= core_result;
    end
  end

  assign result.valid          = out_valid;
  assign result.edge_seen      = out_data.edge_seen;
  assign result.bell_level     = out_data.bell_level;
  assign result.ringing_active = out_data.ringing_active;

endmodule

### design/rcg_cfg_regs.sv
// Configuration register file: on and off durations and the ring limit.
// Depends on rcg_pkg.

module rcg_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [rcg_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [rcg_pkg::CFG_DATA_W-1:0]  wr_data,
  output rcg_pkg::cfg_t                cfg
);
  import rcg_pkg::*;

  cfg_t regs;

  // Each transfer writes the register it addresses; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_ON_DURATION:  regs.on_duration  <= wr_data[DURATION_W-1:0];
        CFG_OFF_DURATION: regs.off_duration <= wr_data[DURATION_W-1:0];
        CFG_RING_LIMIT:   regs.ring_limit   <= wr_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

### design/rcg_cadence.sv
// Cadence core: holds the bell, run, ring count and phase stamp state and
// computes one result per item. Depends on rcg_pkg.

module rcg_cadence (
  input  logic                         clk,
  input  logic                         rst,
  input  rcg_pkg::cfg_t                cfg,
  input  logic                         step,
  input  logic [1:0]                   action,
  input  logic [rcg_pkg::TIME_W-1:0]   time_now,
  output rcg_pkg::result_t             result
);
  import rcg_pkg::*;

  logic               running;
  logic               bell_state;
  logic [COUNT_W-1:0] rings_counted;
  logic [TIME_W-1:0]  phase_stamp;

  logic               running_next;
  logic               bell_state_next;
  logic [COUNT_W-1:0] rings_counted_next;
  logic [TIME_W-1:0]  phase_stamp_next;

  logic [TIME_W-1:0]     elapsed;
  logic [DURATION_W-1:0] length;
  logic                  phase_done;
  logic [COUNT_W-1:0]    rings_inc;
  logic                  limit_hit;
  logic                  edge_seen;

  // Elapsed time wraps modulo 2^32; compare against the current phase length.
  assign elapsed    = time_now - phase_stamp;
  assign length     = bell_state ? cfg.on_duration : cfg.off_duration;
  assign phase_done = elapsed >= {{(TIME_W-DURATION_W){1'b0}}, length};

  // Ring count saturates; the limit is checked on the incremented value.
  assign rings_inc = (rings_counted != COUNT_MAX) ? rings_counted + 1'b1 : rings_counted;
  assign limit_hit = (cfg.ring_limit != '0) && (rings_inc >= cfg.ring_limit);

  // Next state for the item at hand.
  always_comb begin
    running_next       = running;
    bell_state_next    = bell_state;
    rings_counted_next = rings_counted;
    phase_stamp_next   = phase_stamp;
    edge_seen          = 1'b0;
    case (action)
      ACT_TICK: begin
        if (running && phase_done) begin
          edge_seen = 1'b1;
          if (bell_state) begin
            rings_counted_next = rings_inc;
            bell_state_next    = 1'b0;
            if (limit_hit) begin
              running_next = 1'b0;
            end else begin
              phase_stamp_next = time_now;
            end
          end else begin
            bell_state_next  = 1'b1;
            phase_stamp_next = time_now;
          end
        end
      end
      ACT_START: begin
        running_next       = 1'b1;
        bell_state_next    = 1'b1;
        rings_counted_next = '0;
        phase_stamp_next   = time_now;
      end
      ACT_STOP: begin
        running_next    = 1'b0;
        bell_state_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // State advances only when an item is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b0;
      bell_state    <= 1'b0;
      rings_counted <= '0;
      phase_stamp   <= '0;
    end else if (step) begin
      running       <= running_next;
      bell_state    <= bell_state_next;
      rings_counted <= rings_counted_next;
      phase_stamp   <= phase_stamp_next;
    end
  end

  assign result.edge_seen      = edge_seen;
  assign result.bell_level     = bell_state_next;
  assign result.ringing_active = running_next;

endmodule
